// ===== rtl/stffi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stffi_pkg - slot table shared definitions
// Codes, field widths, defaults and the cell token type.
// ----------------------------------------------------------------------------
package stffi_pkg;

    localparam int DEF_SLOTS       = 128;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int MODE_W      = 2;
    localparam int VALUE_IN_W  = 32;
    localparam int INDEX_IN_W  = 8;
    localparam int STATUS_W    = 3;
    localparam int SLOT_OUT_W  = 7;
    localparam int COUNT_OUT_W = 8;

    // request modes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RM_IDX = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RM_VAL = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADIDX   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // operation broadcast to the cells for the request in flight
    typedef enum logic [1:0] {
        OP_NOP = 2'd0,
        OP_INS = 2'd1,
        OP_RMI = 2'd2,
        OP_RMV = 2'd3
    } op_t;

    // control part of the token walking the cell row
    typedef struct packed {
        logic valid;  // token present at this position
        logic done;   // operation already applied upstream
        logic dec;    // a valid slot was cleared
        logic any;    // an occupied slot seen so far
    } tok_ctl_t;

endpackage

// ===== rtl/stffi_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stffi_cell - one slot of the table
// Holds a valid bit and a value, applies the request when the token passes,
// and folds its occupancy into the running summary handed to the next cell.
// ----------------------------------------------------------------------------
module stffi_cell #(
    parameter int IDX_W       = 7,
    parameter int VALUE_WIDTH = stffi_pkg::DEF_VALUE_WIDTH,
    parameter int CELL_ID     = 0
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  stffi_pkg::op_t          op,
    input  logic [VALUE_WIDTH-1:0]  value,
    input  logic [IDX_W-1:0]        index,
    input  stffi_pkg::tok_ctl_t     tok_ctl_in,
    input  logic [IDX_W-1:0]        touched_in,
    input  logic [IDX_W-1:0]        lo_in,
    input  logic [IDX_W-1:0]        hi_in,
    output stffi_pkg::tok_ctl_t     tok_ctl_out,
    output logic [IDX_W-1:0]        touched_out,
    output logic [IDX_W-1:0]        lo_out,
    output logic [IDX_W-1:0]        hi_out
);

    localparam logic [IDX_W-1:0] MY_ID = IDX_W'(CELL_ID);

    logic                   valid_reg;
    logic                   valid_next;
    logic [VALUE_WIDTH-1:0] value_reg;
    stffi_pkg::tok_ctl_t    tok_ctl_reg;
    stffi_pkg::tok_ctl_t    tok_ctl_next;
    logic [IDX_W-1:0]       touched_reg;
    logic [IDX_W-1:0]       touched_next;
    logic [IDX_W-1:0]       lo_reg;
    logic [IDX_W-1:0]       lo_next;
    logic [IDX_W-1:0]       hi_reg;
    logic [IDX_W-1:0]       hi_next;

    logic act_ins;
    logic act_rmi;
    logic act_rmv;
    logic act;

    always_comb begin
        act_ins = tok_ctl_in.valid && (op == stffi_pkg::OP_INS) && !tok_ctl_in.done
                  && !valid_reg;
        act_rmi = tok_ctl_in.valid && (op == stffi_pkg::OP_RMI) && (index == MY_ID);
        act_rmv = tok_ctl_in.valid && (op == stffi_pkg::OP_RMV) && !tok_ctl_in.done
                  && valid_reg && (value_reg == value);
        act     = act_ins || act_rmi || act_rmv;

        if (act_ins) begin
            valid_next = 1'b1;
        end else if (act_rmi || act_rmv) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end

        tok_ctl_next.valid = tok_ctl_in.valid;
        tok_ctl_next.done  = tok_ctl_in.done || act;
        tok_ctl_next.dec   = tok_ctl_in.dec || (act_rmi && valid_reg) || act_rmv;
        tok_ctl_next.any   = tok_ctl_in.any || valid_next;
        touched_next       = act ? MY_ID : touched_in;
        lo_next            = (!tok_ctl_in.any && valid_next) ? MY_ID : lo_in;
        hi_next            = valid_next ? MY_ID : hi_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            tok_ctl_reg <= '0;
        end else begin
            valid_reg   <= valid_next;
            tok_ctl_reg <= tok_ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (act_ins) begin
            value_reg <= value;
        end
        touched_reg <= touched_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
    end

    assign tok_ctl_out = tok_ctl_reg;
    assign touched_out = touched_reg;
    assign lo_out      = lo_reg;
    assign hi_out      = hi_reg;

endmodule

// ===== rtl/slot_table_first_free_insert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_table_first_free_insert - slot allocator with associative delete
// Insert into lowest free slot, remove by index or by first matching value,
// with a status and occupancy summary for every request.
// ----------------------------------------------------------------------------
// The table is a row of SLOTS cells. An accepted request launches a token
// that steps one cell per clock; each cell applies the operation if it is the
// target and adds its occupancy to the running lowest/highest summary. One
// request is in flight at a time: its result is offered only after the token
// has passed the launch register and every cell of the row. The next request
// is accepted as soon as the previous result sits in the output register, even
// while that result waits for m_ready. The occupancy bits are cleared by
// reset; no clearing pass is needed.
module slot_table_first_free_insert #(
    parameter int SLOTS       = stffi_pkg::DEF_SLOTS,
    parameter int VALUE_WIDTH = stffi_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [stffi_pkg::MODE_W-1:0]          s_mode,
    input  logic signed [stffi_pkg::VALUE_IN_W-1:0] s_value,
    input  logic [stffi_pkg::INDEX_IN_W-1:0]      s_slot_index,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [stffi_pkg::STATUS_W-1:0]        m_status,
    output logic [stffi_pkg::SLOT_OUT_W-1:0]      m_slot_touched,
    output logic [stffi_pkg::COUNT_OUT_W-1:0]     m_occupied_count,
    output logic [stffi_pkg::SLOT_OUT_W-1:0]      m_lowest_occupied,
    output logic [stffi_pkg::SLOT_OUT_W-1:0]      m_highest_occupied,
    output logic                                  m_is_empty
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    stffi_pkg::op_t         op_reg;
    stffi_pkg::op_t         op_next;
    stffi_pkg::status_t     pre_status_reg;
    stffi_pkg::status_t     pre_status_next;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    // token chain, position 0 is the launch register
    stffi_pkg::tok_ctl_t tok_ctl [0:SLOTS];
    logic [IDX_W-1:0]    tok_touched [0:SLOTS];
    logic [IDX_W-1:0]    tok_lo [0:SLOTS];
    logic [IDX_W-1:0]    tok_hi [0:SLOTS];
    logic [SLOTS:0]      tok_valid_vec;

    stffi_pkg::tok_ctl_t launch_ctl_reg;

    // finished result
    stffi_pkg::status_t fin_status_reg;
    logic [IDX_W-1:0]   fin_touched_reg;
    logic [IDX_W-1:0]   fin_lo_reg;
    logic [IDX_W-1:0]   fin_hi_reg;
    logic               fin_any_reg;

    logic               accept;
    logic               last_arrive;
    logic               out_load;
    logic [63:0]        value_ext;
    logic [31:0]        index_ext;
    logic               full;
    logic               in_range;
    stffi_pkg::status_t end_status;
    logic               end_ins;
    logic [CNT_W-1:0]   count_inc;

    logic [31:0]        touched_ext;
    logic [31:0]        lo_ext;
    logic [31:0]        hi_ext;
    logic [31:0]        count_ext;

    assign accept      = s_valid && s_ready;
    assign s_ready     = (state_reg == S_IDLE);
    assign value_ext   = {32'd0, s_value};
    assign index_ext   = 32'(s_slot_index);
    assign full        = (count_reg == CNT_W'(SLOTS));
    assign in_range    = (index_ext < 32'(SLOTS));
    assign last_arrive = tok_ctl[SLOTS].valid;
    assign out_load    = (state_reg == S_DONE) && (!m_valid || m_ready);

    // ---------------- request decode ----------------
    always_comb begin
        op_next         = stffi_pkg::OP_NOP;
        pre_status_next = stffi_pkg::ST_OK;
        unique case (s_mode)
            stffi_pkg::MODE_INSERT: begin
                if (full) begin
                    pre_status_next = stffi_pkg::ST_FULL;
                end else begin
                    op_next = stffi_pkg::OP_INS;
                end
            end
            stffi_pkg::MODE_RM_IDX: begin
                if (count_reg == '0) begin
                    pre_status_next = stffi_pkg::ST_EMPTY;
                end else if (!in_range) begin
                    pre_status_next = stffi_pkg::ST_BADIDX;
                end else begin
                    op_next = stffi_pkg::OP_RMI;
                end
            end
            stffi_pkg::MODE_RM_VAL: begin
                if (count_reg == '0) begin
                    pre_status_next = stffi_pkg::ST_EMPTY;
                end else begin
                    op_next = stffi_pkg::OP_RMV;
                end
            end
            default: begin
                op_next = stffi_pkg::OP_NOP;
            end
        endcase
    end

    // ---------------- control ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_SCAN;
            S_SCAN: if (last_arrive) state_next = S_DONE;
            S_DONE: if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        end_ins    = (op_reg == stffi_pkg::OP_INS) && tok_ctl[SLOTS].done;
        count_inc  = count_reg + CNT_W'(end_ins);
        count_next = count_inc - CNT_W'(tok_ctl[SLOTS].dec);
        if ((op_reg == stffi_pkg::OP_RMV) && !tok_ctl[SLOTS].done) begin
            end_status = stffi_pkg::ST_NOTFOUND;
        end else begin
            end_status = pre_status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            launch_ctl_reg <= '0;
            m_valid        <= 1'b0;
        end else begin
            state_reg      <= state_next;
            launch_ctl_reg <= '{valid: accept, done: 1'b0, dec: 1'b0, any: 1'b0};
            if (last_arrive) begin
                count_reg <= count_next;
            end
            if (out_load) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg         <= op_next;
            pre_status_reg <= pre_status_next;
            val_reg        <= value_ext[VALUE_WIDTH-1:0];
            idx_reg        <= index_ext[IDX_W-1:0];
        end
        if (last_arrive) begin
            fin_status_reg  <= end_status;
            fin_touched_reg <= (end_status == stffi_pkg::ST_OK) ? tok_touched[SLOTS] : '0;
            fin_lo_reg      <= tok_lo[SLOTS];
            fin_hi_reg      <= tok_hi[SLOTS];
            fin_any_reg     <= tok_ctl[SLOTS].any;
        end
    end

    // ---------------- cell row ----------------
    assign tok_ctl[0]     = launch_ctl_reg;
    assign tok_touched[0] = '0;
    assign tok_lo[0]      = '0;
    assign tok_hi[0]      = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        stffi_cell #(
            .IDX_W       (IDX_W),
            .VALUE_WIDTH (VALUE_WIDTH),
            .CELL_ID     (g)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .op          (op_reg),
            .value       (val_reg),
            .index       (idx_reg),
            .tok_ctl_in  (tok_ctl[g]),
            .touched_in  (tok_touched[g]),
            .lo_in       (tok_lo[g]),
            .hi_in       (tok_hi[g]),
            .tok_ctl_out (tok_ctl[g+1]),
            .touched_out (tok_touched[g+1]),
            .lo_out      (tok_lo[g+1]),
            .hi_out      (tok_hi[g+1])
        );
    end

    for (genvar v = 0; v <= SLOTS; v++) begin : g_tokv
        assign tok_valid_vec[v] = tok_ctl[v].valid;
    end

    // ---------------- output register ----------------
    assign touched_ext = 32'(fin_touched_reg);
    assign lo_ext      = 32'(fin_lo_reg);
    assign hi_ext      = 32'(fin_hi_reg);
    assign count_ext   = 32'(count_reg);

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status           <= fin_status_reg;
            m_slot_touched     <= touched_ext[stffi_pkg::SLOT_OUT_W-1:0];
            m_occupied_count   <= count_ext[stffi_pkg::COUNT_OUT_W-1:0];
            m_lowest_occupied  <= lo_ext[stffi_pkg::SLOT_OUT_W-1:0];
            m_highest_occupied <= hi_ext[stffi_pkg::SLOT_OUT_W-1:0];
            m_is_empty         <= !fin_any_reg;
        end
    end

    // ---------------- assertions ----------------
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(tok_valid_vec) <= 1)
        else $error("more than one request token in the cell row");

    a_token_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        last_arrive |-> (state_reg == S_SCAN))
        else $error("token reached end of row outside scan");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(SLOTS))
        else $error("occupancy count above table size");

    a_touched_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != stffi_pkg::ST_OK)) |-> (m_slot_touched == '0))
        else $error("slot touched on failed request");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (last_arrive && (SLOTS < 256)) |=> (fin_any_reg == (count_reg != '0)))
        else $error("occupancy summary disagrees with count");

    a_onehot_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("state register not one-hot");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for slot_table_first_free_insert
// Drives insert / remove-by-index / remove-by-value requests with random
// source gaps and sink stalls, predicts every status and occupancy summary
// from a shadow slot table, and compares each result field by field.
// ----------------------------------------------------------------------------
module tb;

    localparam int SLOTS       = stffi_pkg::DEF_SLOTS;
    localparam int N_RANDOM    = 1300;
    localparam int POOL_SIZE   = 12;
    localparam logic [stffi_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef logic [stffi_pkg::MODE_W-1:0]     mode_in_t;
    typedef logic [stffi_pkg::VALUE_IN_W-1:0] value_in_t;
    typedef logic [stffi_pkg::INDEX_IN_W-1:0] index_in_t;

    typedef struct {
        mode_in_t  mode;
        value_in_t value;
        index_in_t slot_index;
    } table_req_t;

    typedef struct {
        stffi_pkg::status_t                status;
        logic [stffi_pkg::SLOT_OUT_W-1:0]  touched;
        logic [stffi_pkg::COUNT_OUT_W-1:0] count;
        logic [stffi_pkg::SLOT_OUT_W-1:0]  lowest;
        logic [stffi_pkg::SLOT_OUT_W-1:0]  highest;
        logic                              empty;
    } table_summary_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    mode_in_t s_mode = stffi_pkg::MODE_INSERT;
    logic signed [stffi_pkg::VALUE_IN_W-1:0] s_value = '0;
    index_in_t s_slot_index = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [stffi_pkg::STATUS_W-1:0]    m_status;
    logic [stffi_pkg::SLOT_OUT_W-1:0]  m_slot_touched;
    logic [stffi_pkg::COUNT_OUT_W-1:0] m_occupied_count;
    logic [stffi_pkg::SLOT_OUT_W-1:0]  m_lowest_occupied;
    logic [stffi_pkg::SLOT_OUT_W-1:0]  m_highest_occupied;
    logic                              m_is_empty;

    slot_table_first_free_insert dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_mode             (s_mode),
        .s_value            (s_value),
        .s_slot_index       (s_slot_index),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_slot_touched     (m_slot_touched),
        .m_occupied_count   (m_occupied_count),
        .m_lowest_occupied  (m_lowest_occupied),
        .m_highest_occupied (m_highest_occupied),
        .m_is_empty         (m_is_empty)
    );

    // shadow of the slot table
    value_in_t shadow_value [SLOTS];
    bit        shadow_used  [SLOTS];
    int        shadow_count = 0;

    table_req_t     pending_reqs [$];
    table_summary_t expected_summaries [$];

    value_in_t value_pool [POOL_SIZE];

    int errors      = 0;
    int n_accepted  = 0;
    int n_checked   = 0;
    int peak_count  = 0;
    int status_hits [5];

    int src_gap    = 0;
    bit src_burst  = 1'b0;
    int sink_stall = 0;
    bit sink_burst = 1'b0;
    int sink_draw;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // apply one request to the shadow table and return the summary it yields
    function automatic table_summary_t table_apply(table_req_t r);
        table_summary_t e;
        int  i;
        int  hit;
        bit  any;
        e.status  = stffi_pkg::ST_OK;
        e.touched = '0;
        hit = -1;
        any = 1'b0;
        case (r.mode)
            stffi_pkg::MODE_INSERT: begin
                if (shadow_count >= SLOTS) begin
                    e.status = stffi_pkg::ST_FULL;
                end else begin
                    for (i = 0; i < SLOTS && hit < 0; i++)
                        if (!shadow_used[i]) hit = i;
                    shadow_value[hit] = r.value;
                    shadow_used[hit]  = 1'b1;
                    shadow_count++;
                    e.touched = hit[stffi_pkg::SLOT_OUT_W-1:0];
                end
            end
            stffi_pkg::MODE_RM_IDX: begin
                if (shadow_count == 0) begin
                    e.status = stffi_pkg::ST_EMPTY;
                end else if (r.slot_index >= SLOTS) begin
                    e.status = stffi_pkg::ST_BADIDX;
                end else begin
                    if (shadow_used[r.slot_index]) begin
                        shadow_used[r.slot_index] = 1'b0;
                        shadow_count--;
                    end
                    e.touched = r.slot_index[stffi_pkg::SLOT_OUT_W-1:0];
                end
            end
            stffi_pkg::MODE_RM_VAL: begin
                if (shadow_count == 0) begin
                    e.status = stffi_pkg::ST_EMPTY;
                end else begin
                    for (i = 0; i < SLOTS && hit < 0; i++)
                        if (shadow_used[i] && shadow_value[i] == r.value) hit = i;
                    if (hit < 0) begin
                        e.status = stffi_pkg::ST_NOTFOUND;
                    end else begin
                        shadow_used[hit] = 1'b0;
                        shadow_count--;
                        e.touched = hit[stffi_pkg::SLOT_OUT_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        e.lowest  = '0;
        e.highest = '0;
        for (i = 0; i < SLOTS; i++) begin
            if (shadow_used[i]) begin
                if (!any) e.lowest = i[stffi_pkg::SLOT_OUT_W-1:0];
                any = 1'b1;
                e.highest = i[stffi_pkg::SLOT_OUT_W-1:0];
            end
        end
        e.count = shadow_count[stffi_pkg::COUNT_OUT_W-1:0];
        e.empty = !any;
        return e;
    endfunction

    function automatic int draw_wait(bit burst);
        return burst ? 0 : $urandom_range(0, 3);
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    task automatic push_req(mode_in_t mode, value_in_t value, index_in_t slot_index);
        table_req_t r;
        r.mode       = mode;
        r.value      = value;
        r.slot_index = slot_index;
        pending_reqs.push_back(r);
    endtask

    function automatic value_in_t pick_value();
        if ($urandom_range(0, 99) < 85) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic index_in_t pick_index();
        if ($urandom_range(0, 99) < 85) return index_in_t'($urandom_range(0, SLOTS - 1));
        return index_in_t'($urandom_range(SLOTS, 255));
    endfunction

    // request source
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                table_req_t r;
                table_summary_t e;
                r.mode       = s_mode;
                r.value      = s_value;
                r.slot_index = s_slot_index;
                e = table_apply(r);
                expected_summaries.push_back(e);
                n_accepted++;
                if (shadow_count > peak_count) peak_count = shadow_count;
            end
            if (!(s_valid && !s_ready)) begin
                if (src_gap != 0) begin
                    s_valid <= 1'b0;
                    src_gap <= src_gap - 1;
                end else if (pending_reqs.size() != 0) begin
                    table_req_t nxt;
                    nxt = pending_reqs.pop_front();
                    s_mode       <= nxt.mode;
                    s_value      <= nxt.value;
                    s_slot_index <= nxt.slot_index;
                    s_valid      <= 1'b1;
                    if ($urandom_range(0, 31) == 0) src_burst = !src_burst;
                    src_gap <= draw_wait(src_burst);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result sink and checker; stalls count down only while a result is offered
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            sink_stall <= 0;
        end else if (m_valid && m_ready) begin
            if (expected_summaries.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                table_summary_t e;
                e = expected_summaries.pop_front();
                check_field("status", 32'(e.status), 32'(m_status));
                check_field("slot_touched", 32'(e.touched), 32'(m_slot_touched));
                check_field("occupied_count", 32'(e.count), 32'(m_occupied_count));
                check_field("lowest_occupied", 32'(e.lowest), 32'(m_lowest_occupied));
                check_field("highest_occupied", 32'(e.highest), 32'(m_highest_occupied));
                check_field("is_empty", 32'(e.empty), 32'(m_is_empty));
                status_hits[e.status]++;
                n_checked++;
            end
            if ($urandom_range(0, 31) == 0) sink_burst = !sink_burst;
            sink_draw = draw_wait(sink_burst);
            sink_stall <= sink_draw;
            m_ready    <= (sink_draw == 0);
        end else if (m_valid && sink_stall != 0) begin
            sink_stall <= sink_stall - 1;
            m_ready    <= (sink_stall == 1);
        end else if (sink_stall == 0) begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int n;
        int phase;
        int blk;
        int j;
        int roll;
        int ins_pct;
        int rmi_pct;
        int rmv_pct;

        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h7FFF_FFFF;
        for (j = 4; j < POOL_SIZE; j++) value_pool[j] = $urandom;

        // directed opening
        push_req(stffi_pkg::MODE_RM_IDX, 32'h0, 8'd0);            // remove on empty table
        push_req(stffi_pkg::MODE_RM_VAL, 32'h0, 8'd255);          // by value on empty table
        push_req(stffi_pkg::MODE_RM_IDX, 32'h0, 8'd255);          // empty wins over bad index
        push_req(MODE_UNUSED, 32'hFFFF_FFFF, 8'd255);             // unused mode, empty table
        push_req(stffi_pkg::MODE_INSERT, 32'h8000_0000, 8'd0);
        push_req(stffi_pkg::MODE_INSERT, 32'h7FFF_FFFF, 8'd0);
        push_req(stffi_pkg::MODE_INSERT, 32'hFFFF_FFFF, 8'd0);
        push_req(stffi_pkg::MODE_INSERT, 32'h0000_0000, 8'd0);
        push_req(stffi_pkg::MODE_INSERT, 32'h0000_0005, 8'd0);
        push_req(stffi_pkg::MODE_INSERT, 32'h0000_0005, 8'd0);
        push_req(stffi_pkg::MODE_RM_IDX, 32'h0, 8'd255);          // bad index
        push_req(stffi_pkg::MODE_RM_IDX, 32'h0, 8'd128);          // first bad index
        push_req(stffi_pkg::MODE_RM_IDX, 32'h0, 8'd127);          // free slot in range
        push_req(stffi_pkg::MODE_RM_IDX, 32'h0, 8'd1);            // clears a hole
        push_req(stffi_pkg::MODE_INSERT, 32'h1234_5678, 8'd0);    // refills the hole
        push_req(stffi_pkg::MODE_RM_VAL, 32'hDEAD_BEEF, 8'd0);    // no match
        push_req(stffi_pkg::MODE_RM_VAL, 32'h0000_0005, 8'd0);    // lowest of two duplicates
        push_req(stffi_pkg::MODE_RM_VAL, 32'hFFFF_FFFF, 8'd0);
        push_req(MODE_UNUSED, 32'h5555_AAAA, 8'd77);
        push_req(stffi_pkg::MODE_RM_IDX, 32'h0, 8'd0);
        push_req(stffi_pkg::MODE_RM_VAL, 32'h0000_0005, 8'd0);    // highest slot cleared
        push_req(stffi_pkg::MODE_INSERT, 32'h0000_0001, 8'd0);

        // random part: fill, mixed and drain phases in turn, so the table
        // reaches both full and empty repeatedly
        n = 0;
        phase = 0;
        while (n < N_RANDOM) begin
            blk = $urandom_range(150, 250);
            case (phase % 3)
                0:       begin ins_pct = 88; rmi_pct = 5;  rmv_pct = 5;  end
                1:       begin ins_pct = 45; rmi_pct = 25; rmv_pct = 27; end
                default: begin ins_pct = 5;  rmi_pct = 30; rmv_pct = 62; end
            endcase
            for (j = 0; j < blk && n < N_RANDOM; j++) begin
                roll = $urandom_range(0, 99);
                if (roll < ins_pct) begin
                    push_req(stffi_pkg::MODE_INSERT, pick_value(),
                             index_in_t'($urandom_range(0, 255)));
                    n++;
                end else if (roll < ins_pct + rmi_pct) begin
                    push_req(stffi_pkg::MODE_RM_IDX, $urandom, pick_index());
                    n++;
                end else if (roll < ins_pct + rmi_pct + rmv_pct) begin
                    push_req(stffi_pkg::MODE_RM_VAL, pick_value(),
                             index_in_t'($urandom_range(0, 255)));
                    n++;
                end else begin
                    push_req(MODE_UNUSED, $urandom, index_in_t'($urandom_range(0, 255)));
                end
            end
            phase++;
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_valid) @(posedge aclk);
        while (expected_summaries.size() != 0) @(posedge aclk);
        repeat (2 * SLOTS + 20) @(posedge aclk);

        if (n_checked != n_accepted || expected_summaries.size() != 0) begin
            $error("results checked %0d, requests accepted %0d", n_checked, n_accepted);
            errors++;
        end

        $display("requests %0d, results checked %0d, peak occupancy %0d of %0d",
                 n_accepted, n_checked, peak_count, SLOTS);
        $display("status ok %0d, full %0d, empty %0d, bad index %0d, not found %0d",
                 status_hits[stffi_pkg::ST_OK], status_hits[stffi_pkg::ST_FULL],
                 status_hits[stffi_pkg::ST_EMPTY], status_hits[stffi_pkg::ST_BADIDX],
                 status_hits[stffi_pkg::ST_NOTFOUND]);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/stffi_pkg.sv
rtl/stffi_cell.sv
rtl/slot_table_first_free_insert.sv
tb/tb.sv
